@@ rtl/gdai_pkg.sv @@
// Shared types and constants for the gyro DCM attitude integrator.
// Used by the top level, the shared multiplier and the checker; no dependencies.
`default_nettype none

package gdai_pkg;

	localparam int RAW_W      = 16;
	localparam int DIFF_W     = RAW_W + 1;
	localparam int DIV_W      = 10;
	localparam int STEP_W     = 7;
	localparam int NMAG_W     = RAW_W + STEP_W;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MUL_W     = 48;
	localparam int MUL_DIGIT = MUL_W / 2;
	localparam int PROD_W    = 2 * MUL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIVISOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd4;

	localparam logic signed [RAW_W-1:0] OFFSET_X_RST     = -16'sd166;
	localparam logic signed [RAW_W-1:0] OFFSET_Y_RST     = 16'sd189;
	localparam logic signed [RAW_W-1:0] OFFSET_Z_RST     = 16'sd18;
	localparam logic [DIV_W-1:0]        RATE_DIVISOR_RST = 10'd113;
	localparam logic [STEP_W-1:0]       TIME_STEP_RST    = 7'd2;

	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_Z   = 2'd2;
	localparam logic [1:0] DIM_LAST = 2'd2;

	// pi in Q60 and centidegrees per half turn
	localparam logic [63:0] PI_Q60             = 64'h3243F6A8885A308D;
	localparam logic [63:0] CDEG_PER_HALF_TURN = 64'd18000;
	localparam int          THETA_SHIFT        = 8;

	typedef logic [MUL_W-1:0]         mul_op_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [PROD_W:0]          rnd_t;
	typedef logic [NMAG_W-1:0]        nmag_t;
	typedef logic signed [OUT_W-1:0]  out_word_t;

	typedef struct packed {
		logic    start;
		mul_op_t a;
		mul_op_t b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		prod_t prod;
	} mul_rsp_t;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_DLOAD = 12'b0000_0000_0010,
		S_DIV   = 12'b0000_0000_0100,
		S_NMUL  = 12'b0000_0000_1000,
		S_TGO   = 12'b0000_0001_0000,
		S_TWAIT = 12'b0000_0010_0000,
		S_RD    = 12'b0000_0100_0000,
		S_RDW   = 12'b0000_1000_0000,
		S_PGO   = 12'b0001_0000_0000,
		S_PWAIT = 12'b0010_0000_0000,
		S_SUM   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/gdai_mul.sv @@
// Shared unsigned 48x48 multiplier built from one 24x24 multiplier.
// Depends on gdai_pkg for operand, product and handshake struct types.
`default_nettype none

module gdai_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  gdai_pkg::mul_req_t req,
	output gdai_pkg::mul_rsp_t rsp
);

	gdai_pkg::mul_op_t a_q;
	gdai_pkg::mul_op_t b_q;
	logic [1:0] cnt_q;
	logic busy_q;
	logic [2*gdai_pkg::MUL_DIGIT-1:0] pp_s1;
	logic [1:0] sh_s1;
	logic vld_s1;
	logic last_s1;
	gdai_pkg::prod_t acc_q;
	gdai_pkg::prod_t pp_shifted;
	logic done_q;

	logic [gdai_pkg::MUL_DIGIT-1:0] dig_a;
	logic [gdai_pkg::MUL_DIGIT-1:0] dig_b;
	logic [1:0] sh;

	assign dig_a = cnt_q[0] ? a_q[gdai_pkg::MUL_W-1:gdai_pkg::MUL_DIGIT]
	                        : a_q[gdai_pkg::MUL_DIGIT-1:0];
	assign dig_b = cnt_q[1] ? b_q[gdai_pkg::MUL_W-1:gdai_pkg::MUL_DIGIT]
	                        : b_q[gdai_pkg::MUL_DIGIT-1:0];
	assign sh = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};

	always_comb begin
		unique case (sh_s1)
			2'd0:    pp_shifted = gdai_pkg::prod_t'(pp_s1);
			2'd1:    pp_shifted = gdai_pkg::prod_t'(pp_s1) << gdai_pkg::MUL_DIGIT;
			2'd2:    pp_shifted = gdai_pkg::prod_t'(pp_s1) << (2 * gdai_pkg::MUL_DIGIT);
			default: pp_shifted = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (cnt_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pp_shifted;
		end
		if (busy_q) begin
			pp_s1 <= dig_a * dig_b;
			sh_s1 <= sh;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

@@ rtl/gyro_dcm_attitude_integrator_unit.sv @@
// Top level of the gyro DCM attitude integrator: sequencer, divider, matrix memory.
// Depends on gdai_pkg and gdai_mul.
//
// Usage:
//  - Configuration: cfg_we/cfg_index/cfg_data write the three axis offsets, the
//    rate divisor and the time step; write only while the block is idle.
//  - Input: one gyro word (rate_x/y/z) is taken when in_valid is high and
//    in_stall is low. in_stall stays high while a word is being worked on.
//  - Output: one word r11..r33 (the updated matrix) per input word, offered on
//    out_valid and held while out_stall is high.
//  - Sequence from the accepting edge to out_valid: per axis a 16-step
//    restoring divide and a product on the shared multiplier, then per matrix
//    column three memory reads and six products, then the load of the output
//    register. Each 48x48 product runs on the single 24x24 multiplier, which with
//    the divider sets the rate.
//  - One word is in flight; the next is taken as soon as the result moves to the
//    output register, even while the receiver still stalls the previous result.
//  - Reset: the matrix reads as identity (per-entry valid bits), registers take
//    their default values, no result is pending.
`default_nettype none

module gyro_dcm_attitude_integrator_unit #(
	parameter int ELEMENT_WIDTH = 32,
	parameter int FRAC_BITS     = 28
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                cfg_we,
	input  logic [gdai_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gdai_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gdai_pkg::RAW_W-1:0]   rate_x,
	input  logic signed [gdai_pkg::RAW_W-1:0]   rate_y,
	input  logic signed [gdai_pkg::RAW_W-1:0]   rate_z,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gdai_pkg::OUT_W-1:0]   r11,
	output logic signed [gdai_pkg::OUT_W-1:0]   r12,
	output logic signed [gdai_pkg::OUT_W-1:0]   r13,
	output logic signed [gdai_pkg::OUT_W-1:0]   r21,
	output logic signed [gdai_pkg::OUT_W-1:0]   r22,
	output logic signed [gdai_pkg::OUT_W-1:0]   r23,
	output logic signed [gdai_pkg::OUT_W-1:0]   r31,
	output logic signed [gdai_pkg::OUT_W-1:0]   r32,
	output logic signed [gdai_pkg::OUT_W-1:0]   r33
);

	localparam int SumW   = ELEMENT_WIDTH + 2;
	localparam int DMagW  = gdai_pkg::RAW_W;
	localparam int DCntW  = $clog2(DMagW);
	localparam int MemD   = 9;
	localparam int MemAW  = $clog2(MemD);
	localparam logic [DCntW-1:0] DivLast = DCntW'(DMagW - 1);

	localparam logic signed [ELEMENT_WIDTH-1:0] ElMax = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
	localparam logic signed [ELEMENT_WIDTH-1:0] ElMin = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
	localparam logic signed [ELEMENT_WIDTH-1:0] ElOne =
		(FRAC_BITS < ELEMENT_WIDTH - 1) ? ({{(ELEMENT_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS)
		                                : ElMax;

	localparam logic [63:0] RadCdegQ60 = gdai_pkg::PI_Q60 / gdai_pkg::CDEG_PER_HALF_TURN;
	localparam logic [63:0] RadK =
		(RadCdegQ60 + (64'd1 << (51 - FRAC_BITS))) >> (52 - FRAC_BITS);
	localparam gdai_pkg::rnd_t RndHalfTheta = gdai_pkg::rnd_t'(1) << (gdai_pkg::THETA_SHIFT - 1);
	localparam gdai_pkg::rnd_t RndHalfProd  = gdai_pkg::rnd_t'(1) << (FRAC_BITS - 1);

	gdai_pkg::state_t state_q;

	logic signed [gdai_pkg::RAW_W-1:0] off_q [3];
	logic [gdai_pkg::DIV_W-1:0]        div_q;
	logic [gdai_pkg::STEP_W-1:0]       step_q;

	logic signed [gdai_pkg::RAW_W-1:0] raw_q [3];
	logic [1:0]                        axis_q;
	logic [DCntW-1:0]                  bit_q;
	logic [DMagW-1:0]                  dq_q;
	logic [gdai_pkg::DIV_W-1:0]        rem_q;
	logic                              q_neg_q;
	gdai_pkg::nmag_t                   n_mag_q;
	logic                              rnd_neg_q;
	logic signed [ELEMENT_WIDTH-1:0]   theta_q [3];
	logic signed [ELEMENT_WIDTH-1:0]   tm_q [2];
	logic signed [ELEMENT_WIDTH-1:0]   colv_q [3];
	logic signed [ELEMENT_WIDTH-1:0]   stage_q [MemD];
	logic signed [gdai_pkg::OUT_W-1:0] out_q [MemD];
	logic                              out_valid_q;
	logic [1:0]                        row_q;
	logic [1:0]                        colsel_q;
	logic                              term_q;

	logic signed [ELEMENT_WIDTH-1:0]   mem_q [MemD];
	logic [MemD-1:0]                   vld_q;
	logic signed [ELEMENT_WIDTH-1:0]   rd_data_s1;
	logic                              rd_vld_s1;
	logic                              rd_s1;
	logic [1:0]                        row_s1;

	logic signed [gdai_pkg::DIFF_W-1:0] diff;
	logic [gdai_pkg::DIFF_W-1:0]        dmag;
	logic [gdai_pkg::DIV_W-1:0]         div_eff;
	logic [gdai_pkg::DIV_W:0]           trial;
	logic [gdai_pkg::DIV_W:0]           trial_sub;
	logic                               ge;
	logic [MemAW-1:0]                   addr;
	logic signed [ELEMENT_WIDTH-1:0]    rd_val;

	logic [1:0]                         sel_axis;
	logic                               sel_negate;
	logic [1:0]                         sel_src;
	logic signed [ELEMENT_WIDTH-1:0]    th;
	logic signed [ELEMENT_WIDTH-1:0]    cv;
	logic [ELEMENT_WIDTH-1:0]           th_mag;
	logic [ELEMENT_WIDTH-1:0]           cv_mag;
	logic                               th_neg;
	logic                               prod_neg;

	gdai_pkg::mul_req_t                 mul_req;
	gdai_pkg::mul_rsp_t                 mul_rsp;
	logic                               theta_mode;
	gdai_pkg::rnd_t                     rnd_sum;
	gdai_pkg::rnd_t                     rnd_shift;
	logic [ELEMENT_WIDTH-1:0]           lim;
	logic [ELEMENT_WIDTH-1:0]           sat_mag;
	logic signed [ELEMENT_WIDTH-1:0]    rnd_val;
	logic signed [SumW-1:0]             sum;
	logic signed [ELEMENT_WIDTH-1:0]    sum_sat;
	logic                               out_load;

	gdai_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// rate divide
	assign diff    = {raw_q[axis_q][gdai_pkg::RAW_W-1], raw_q[axis_q]}
	               - {off_q[axis_q][gdai_pkg::RAW_W-1], off_q[axis_q]};
	assign dmag    = diff[gdai_pkg::DIFF_W-1] ? -diff : diff;
	assign div_eff = (div_q == '0) ? gdai_pkg::DIV_W'(1) : div_q;
	assign trial   = {rem_q, dq_q[DMagW-1]};
	assign trial_sub = trial - {1'b0, div_eff};
	assign ge      = (trial >= {1'b0, div_eff});

	// matrix addressing and read data
	assign addr   = MemAW'({2'b00, row_q}) + MemAW'({1'b0, row_q, 1'b0}) + MemAW'({2'b00, colsel_q});
	assign rd_val = rd_vld_s1 ? rd_data_s1 : ((row_s1 == colsel_q) ? ElOne : '0);

	always_comb begin
		unique case ({row_q, term_q})
			3'b00_0: begin sel_axis = gdai_pkg::AXIS_Z; sel_negate = 1'b1; sel_src = 2'd1; end
			3'b00_1: begin sel_axis = gdai_pkg::AXIS_Y; sel_negate = 1'b0; sel_src = 2'd2; end
			3'b01_0: begin sel_axis = gdai_pkg::AXIS_Z; sel_negate = 1'b0; sel_src = 2'd0; end
			3'b01_1: begin sel_axis = gdai_pkg::AXIS_X; sel_negate = 1'b1; sel_src = 2'd2; end
			3'b10_0: begin sel_axis = gdai_pkg::AXIS_Y; sel_negate = 1'b1; sel_src = 2'd0; end
			3'b10_1: begin sel_axis = gdai_pkg::AXIS_X; sel_negate = 1'b0; sel_src = 2'd1; end
			default: begin sel_axis = gdai_pkg::AXIS_X; sel_negate = 1'b0; sel_src = 2'd0; end
		endcase
	end

	assign th       = theta_q[sel_axis];
	assign cv       = colv_q[sel_src];
	assign th_mag   = th[ELEMENT_WIDTH-1] ? -th : th;
	assign cv_mag   = cv[ELEMENT_WIDTH-1] ? -cv : cv;
	assign th_neg   = sel_negate ? (!th[ELEMENT_WIDTH-1] && (th != '0)) : th[ELEMENT_WIDTH-1];
	assign prod_neg = th_neg ^ cv[ELEMENT_WIDTH-1];

	always_comb begin
		mul_req.start = (state_q == gdai_pkg::S_TGO) || (state_q == gdai_pkg::S_PGO);
		if (state_q == gdai_pkg::S_TGO) begin
			mul_req.a = gdai_pkg::mul_op_t'(n_mag_q);
			mul_req.b = RadK[gdai_pkg::MUL_W-1:0];
		end else begin
			mul_req.a = gdai_pkg::mul_op_t'(th_mag);
			mul_req.b = gdai_pkg::mul_op_t'(cv_mag);
		end
	end

	// round half away from zero, saturate, apply sign
	assign theta_mode = (state_q == gdai_pkg::S_TWAIT);
	assign rnd_sum    = {1'b0, mul_rsp.prod} + (theta_mode ? RndHalfTheta : RndHalfProd);
	assign rnd_shift  = theta_mode ? (rnd_sum >> gdai_pkg::THETA_SHIFT) : (rnd_sum >> FRAC_BITS);
	assign lim        = rnd_neg_q ? ElMin : ElMax;
	assign sat_mag    = (rnd_shift > gdai_pkg::rnd_t'(lim)) ? lim : rnd_shift[ELEMENT_WIDTH-1:0];
	assign rnd_val    = rnd_neg_q ? -sat_mag : sat_mag;

	assign sum = SumW'(colv_q[row_q]) + SumW'(tm_q[0]) + SumW'(tm_q[1]);
	always_comb begin
		priority if (sum > SumW'(ElMax)) begin
			sum_sat = ElMax;
		end else if (sum < SumW'(ElMin)) begin
			sum_sat = ElMin;
		end else begin
			sum_sat = sum[ELEMENT_WIDTH-1:0];
		end
	end

	assign out_load = (state_q == gdai_pkg::S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdai_pkg::S_IDLE;
			off_q[0]    <= gdai_pkg::OFFSET_X_RST;
			off_q[1]    <= gdai_pkg::OFFSET_Y_RST;
			off_q[2]    <= gdai_pkg::OFFSET_Z_RST;
			div_q       <= gdai_pkg::RATE_DIVISOR_RST;
			step_q      <= gdai_pkg::TIME_STEP_RST;
			axis_q      <= gdai_pkg::AXIS_X;
			bit_q       <= '0;
			row_q       <= '0;
			colsel_q    <= '0;
			term_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gdai_pkg::CFG_OFFSET_X:     off_q[0] <= cfg_data;
					gdai_pkg::CFG_OFFSET_Y:     off_q[1] <= cfg_data;
					gdai_pkg::CFG_OFFSET_Z:     off_q[2] <= cfg_data;
					gdai_pkg::CFG_RATE_DIVISOR: div_q    <= cfg_data[gdai_pkg::DIV_W-1:0];
					gdai_pkg::CFG_TIME_STEP:    step_q   <= cfg_data[gdai_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			rd_s1 <= (state_q == gdai_pkg::S_RD);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				gdai_pkg::S_IDLE: begin
					if (in_valid) begin
						axis_q  <= gdai_pkg::AXIS_X;
						state_q <= gdai_pkg::S_DLOAD;
					end
				end
				gdai_pkg::S_DLOAD: begin
					bit_q   <= '0;
					state_q <= gdai_pkg::S_DIV;
				end
				gdai_pkg::S_DIV: begin
					bit_q <= bit_q + DCntW'(1);
					if (bit_q == DivLast) begin
						state_q <= gdai_pkg::S_NMUL;
					end
				end
				gdai_pkg::S_NMUL: state_q <= gdai_pkg::S_TGO;
				gdai_pkg::S_TGO:  state_q <= gdai_pkg::S_TWAIT;
				gdai_pkg::S_TWAIT: begin
					if (mul_rsp.done) begin
						if (axis_q == gdai_pkg::AXIS_Z) begin
							row_q    <= '0;
							colsel_q <= '0;
							state_q  <= gdai_pkg::S_RD;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= gdai_pkg::S_DLOAD;
						end
					end
				end
				gdai_pkg::S_RD: begin
					if (row_q == gdai_pkg::DIM_LAST) begin
						row_q   <= '0;
						state_q <= gdai_pkg::S_RDW;
					end else begin
						row_q <= row_q + 2'd1;
					end
				end
				gdai_pkg::S_RDW: begin
					term_q  <= 1'b0;
					state_q <= gdai_pkg::S_PGO;
				end
				gdai_pkg::S_PGO: state_q <= gdai_pkg::S_PWAIT;
				gdai_pkg::S_PWAIT: begin
					if (mul_rsp.done) begin
						if (!term_q) begin
							term_q  <= 1'b1;
							state_q <= gdai_pkg::S_PGO;
						end else begin
							state_q <= gdai_pkg::S_SUM;
						end
					end
				end
				gdai_pkg::S_SUM: begin
					vld_q[addr] <= 1'b1;
					term_q      <= 1'b0;
					if (row_q == gdai_pkg::DIM_LAST) begin
						row_q <= '0;
						if (colsel_q == gdai_pkg::DIM_LAST) begin
							state_q <= gdai_pkg::S_DONE;
						end else begin
							colsel_q <= colsel_q + 2'd1;
							state_q  <= gdai_pkg::S_RD;
						end
					end else begin
						row_q   <= row_q + 2'd1;
						state_q <= gdai_pkg::S_PGO;
					end
				end
				gdai_pkg::S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= gdai_pkg::S_IDLE;
					end
				end
				default: state_q <= gdai_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gdai_pkg::S_IDLE) && in_valid) begin
			raw_q[0] <= rate_x;
			raw_q[1] <= rate_y;
			raw_q[2] <= rate_z;
		end
		if (state_q == gdai_pkg::S_DLOAD) begin
			dq_q    <= dmag[DMagW-1:0];
			rem_q   <= '0;
			q_neg_q <= diff[gdai_pkg::DIFF_W-1];
		end
		if (state_q == gdai_pkg::S_DIV) begin
			dq_q  <= {dq_q[DMagW-2:0], ge};
			rem_q <= ge ? trial_sub[gdai_pkg::DIV_W-1:0] : trial[gdai_pkg::DIV_W-1:0];
		end
		if (state_q == gdai_pkg::S_NMUL) begin
			n_mag_q <= gdai_pkg::nmag_t'(dq_q) * gdai_pkg::nmag_t'(step_q);
		end
		if (state_q == gdai_pkg::S_TGO) begin
			rnd_neg_q <= q_neg_q;
		end
		if (state_q == gdai_pkg::S_PGO) begin
			rnd_neg_q <= prod_neg;
		end
		if ((state_q == gdai_pkg::S_TWAIT) && mul_rsp.done) begin
			theta_q[axis_q] <= rnd_val;
		end
		if ((state_q == gdai_pkg::S_PWAIT) && mul_rsp.done) begin
			tm_q[term_q] <= rnd_val;
		end
		if (state_q == gdai_pkg::S_RD) begin
			rd_data_s1 <= mem_q[addr];
			rd_vld_s1  <= vld_q[addr];
			row_s1     <= row_q;
		end
		if (rd_s1) begin
			colv_q[row_s1] <= rd_val;
		end
		if (state_q == gdai_pkg::S_SUM) begin
			mem_q[addr]   <= sum_sat;
			stage_q[addr] <= sum_sat;
		end
		if (out_load) begin
			for (int k = 0; k < MemD; k++) begin
				out_q[k] <= gdai_pkg::out_word_t'(stage_q[k]);
			end
		end
	end

	assign in_stall  = (state_q != gdai_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign r11 = out_q[0];
	assign r12 = out_q[1];
	assign r13 = out_q[2];
	assign r21 = out_q[3];
	assign r22 = out_q[4];
	assign r23 = out_q[5];
	assign r31 = out_q[6];
	assign r32 = out_q[7];
	assign r33 = out_q[8];

endmodule

`default_nettype wire

@@ rtl/gdai_checker.sv @@
// Port-level checker for the gyro DCM attitude integrator, bound to the top level.
// Depends on gdai_pkg for port widths.
`default_nettype none

module gdai_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [gdai_pkg::OUT_W-1:0] r11,
	input logic signed [gdai_pkg::OUT_W-1:0] r33
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(r11) && $stable(r33))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again before work on the word finished");

	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result presented without returning to idle");

endmodule

bind gyro_dcm_attitude_integrator_unit gdai_checker u_gdai_checker (.*);

`default_nettype wire
